// File: hdl/bmp_stream_to_rgba_pixels_core_defines.svh
// Assertion macros used by the checker of the BMP to RGBA decoder.
`ifndef BMP_STREAM_TO_RGBA_PIXELS_CORE_DEFINES_SVH
`define BMP_STREAM_TO_RGBA_PIXELS_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BMP2RGBA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BMP2RGBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/bmp2rgba_pkg.sv
// Types, constants and helper functions of the BMP to RGBA decoder.
`default_nettype none
package bmp2rgba_pkg;

	localparam int unsigned MAX_DIMENSION_DEF = 4096;
	localparam int unsigned DIM_W = 13;
	localparam int unsigned RESULT_DEPTH = 4;
	localparam int unsigned RESULT_PTR_W = $clog2(RESULT_DEPTH);

	localparam logic [31:0] POS_SIG_B    = 32'd0;
	localparam logic [31:0] POS_SIG_M    = 32'd1;
	localparam logic [31:0] POS_OFFSET   = 32'd13;
	localparam logic [31:0] POS_DIB      = 32'd17;
	localparam logic [31:0] POS_WIDTH    = 32'd21;
	localparam logic [31:0] POS_HEIGHT   = 32'd25;
	localparam logic [31:0] POS_PLANES   = 32'd27;
	localparam logic [31:0] POS_BPP      = 32'd29;
	localparam logic [31:0] POS_COMPRESS = 32'd33;
	localparam logic [31:0] HEADER_BYTES = 32'd54;
	localparam logic [31:0] HEADER_LAST  = HEADER_BYTES - 32'd1;
	localparam logic [31:0] MIN_DIB_SIZE = 32'd40;

	localparam logic [7:0]  SIG_B      = 8'h42;
	localparam logic [7:0]  SIG_M      = 8'h4D;
	localparam logic [15:0] BPP_24     = 16'd24;
	localparam logic [15:0] BPP_32     = 16'd32;
	localparam logic [15:0] ONE_PLANE  = 16'd1;
	localparam logic [7:0]  ALPHA_FULL = 8'hFF;

	localparam logic KIND_PIXEL  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_SIG     = 3'd1,
		ST_BAD_DIB     = 3'd2,
		ST_UNSUPPORTED = 3'd3,
		ST_TRUNCATED   = 3'd4,
		ST_TOO_LARGE   = 3'd5,
		ST_OFFSET      = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_SKIP   = 4'b0010,
		PH_PIXELS = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic        item_kind;
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [2:0]  status_code;
		logic        last_of_run;
	} result_t;

	typedef struct packed {
		logic    has_pixel;
		logic    has_status;
		result_t pixel;
		result_t status;
	} decode_out_t;

	// Rank of a header fault; a higher rank wins over a lower one.
	function automatic logic [2:0] severity(input status_t code);
		logic [2:0] rank;
		unique case (code)
			ST_BAD_SIG:     rank = 3'd5;
			ST_BAD_DIB:     rank = 3'd4;
			ST_UNSUPPORTED: rank = 3'd3;
			ST_TOO_LARGE:   rank = 3'd2;
			ST_OFFSET:      rank = 3'd1;
			default:        rank = 3'd0;
		endcase
		return rank;
	endfunction

endpackage
`default_nettype wire

// File: hdl/bmp2rgba_byte_if.sv
// Byte channel carrying the raw BMP file into the decoder.
`default_nettype none
interface bmp2rgba_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_file;

	modport source (output valid, data_byte, end_of_file, input ready);
	modport sink (input valid, data_byte, end_of_file, output ready);
endinterface
`default_nettype wire

// File: hdl/bmp2rgba_result_if.sv
// Result channel carrying pixels and end-of-file status out of the decoder.
`default_nettype none
interface bmp2rgba_result_if;
	logic        valid;
	logic        ready;
	logic        item_kind;
	logic [11:0] pixel_x;
	logic [11:0] pixel_y;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [2:0]  status_code;
	logic        last_of_run;

	modport source (output valid, item_kind, pixel_x, pixel_y, red, green, blue, alpha,
		status_code, last_of_run, input ready);
	modport sink (input valid, item_kind, pixel_x, pixel_y, red, green, blue, alpha,
		status_code, last_of_run, output ready);
endinterface
`default_nettype wire

// File: hdl/bmp2rgba_decode.sv
// Header parser and pixel assembler: file state plus one byte of decode logic.
`default_nettype none
module bmp2rgba_decode #(
	parameter int unsigned MAX_DIMENSION = bmp2rgba_pkg::MAX_DIMENSION_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [7:0]                 data_byte,
	input  logic                       end_of_file,
	output bmp2rgba_pkg::decode_out_t  decoded
);
	import bmp2rgba_pkg::*;

	localparam logic [31:0] MAX_DIM = 32'(MAX_DIMENSION);

	logic [31:0]      pos_q, pos_n;
	logic [31:0]      shift_q, shift_n;
	logic [31:0]      data_start_q, data_start_n;
	logic [DIM_W-1:0] width_q, width_n;
	logic [DIM_W-1:0] height_q, height_n;
	logic             top_down_q, top_down_n;
	logic             four_q, four_n;
	logic [DIM_W-1:0] col_q, col_n;
	logic [DIM_W-1:0] row_q, row_n;
	logic [14:0]      bir_q, bir_n;
	logic [1:0]       sub_q, sub_n;
	logic [23:0]      hold_q, hold_n;
	status_t          err_q, err_n;
	phase_t           phase_q, phase_n;
	logic [15:0]      row_data_q, row_data_n;
	logic [14:0]      row_last_q, row_last_n;

	logic [31:0]      hs;
	logic [31:0]      mag;
	logic [31:0]      dim_m1;
	status_t          code_new;
	logic [15:0]      wp;
	logic [15:0]      data_len;
	logic [15:0]      stride;
	logic [15:0]      stride_m1;
	logic             in_pixels;
	logic             emit;
	logic [1:0]       last_sub;
	logic [DIM_W-1:0] y_row;
	status_t          status;

	always_comb begin
		pos_n        = (pos_q != '1) ? pos_q + 32'd1 : pos_q;
		shift_n      = shift_q;
		data_start_n = data_start_q;
		width_n      = width_q;
		height_n     = height_q;
		top_down_n   = top_down_q;
		four_n       = four_q;
		col_n        = col_q;
		row_n        = row_q;
		bir_n        = bir_q;
		sub_n        = sub_q;
		hold_n       = hold_q;
		err_n        = err_q;
		phase_n      = phase_q;
		row_data_n   = row_data_q;
		row_last_n   = row_last_q;
		code_new     = ST_OK;
		emit         = 1'b0;

		hs     = {data_byte, shift_q[31:8]};
		mag    = hs[31] ? (32'd0 - hs) : hs;
		dim_m1 = (hs[31] ? mag : hs) - 32'd1;

		wp        = 16'({3'b000, width_q}) + 16'd1;
		data_len  = four_q ? {wp[13:0], 2'b00} : wp + {wp[14:0], 1'b0};
		stride    = (data_len + 16'd3) & ~16'd3;
		stride_m1 = stride - 16'd1;

		in_pixels = (phase_q == PH_PIXELS) || ((phase_q == PH_SKIP) && (pos_q >= data_start_q));
		last_sub  = four_q ? 2'd3 : 2'd2;
		y_row     = top_down_q ? row_q : height_q - row_q;

		if (phase_q == PH_HEADER) begin
			shift_n = hs;
			if (pos_q == POS_SIG_B && data_byte != SIG_B) code_new = ST_BAD_SIG;
			if (pos_q == POS_SIG_M && data_byte != SIG_M) code_new = ST_BAD_SIG;
			if (pos_q == POS_OFFSET) begin
				data_start_n = hs;
				if (hs < HEADER_BYTES) code_new = ST_OFFSET;
			end
			if (pos_q == POS_DIB && hs < MIN_DIB_SIZE) code_new = ST_BAD_DIB;
			if (pos_q == POS_WIDTH) begin
				if (hs == 32'd0 || hs[31]) code_new = ST_UNSUPPORTED;
				else if (hs > MAX_DIM) code_new = ST_TOO_LARGE;
				else width_n = dim_m1[DIM_W-1:0];
			end
			if (pos_q == POS_HEIGHT) begin
				if (hs == 32'd0) code_new = ST_UNSUPPORTED;
				else if (mag > MAX_DIM) code_new = ST_TOO_LARGE;
				else begin
					height_n   = dim_m1[DIM_W-1:0];
					top_down_n = hs[31];
				end
			end
			if (pos_q == POS_PLANES && hs[31:16] != ONE_PLANE) code_new = ST_UNSUPPORTED;
			if (pos_q == POS_BPP) begin
				if (hs[31:16] == BPP_24) four_n = 1'b0;
				else if (hs[31:16] == BPP_32) four_n = 1'b1;
				else code_new = ST_UNSUPPORTED;
			end
			if (pos_q == POS_COMPRESS && hs != 32'd0) code_new = ST_UNSUPPORTED;
			if (severity(code_new) > severity(err_q)) err_n = code_new;
			if (pos_q == HEADER_LAST) begin
				// freeze the row geometry for the pixel phase
				row_data_n = data_len;
				row_last_n = stride_m1[14:0];
				if (err_n != ST_OK) phase_n = PH_DONE;
				else if (data_start_q == HEADER_BYTES) phase_n = PH_PIXELS;
				else phase_n = PH_SKIP;
			end
		end else if (in_pixels) begin
			phase_n = PH_PIXELS;
			if (16'({1'b0, bir_q}) < row_data_q) begin
				unique case (sub_q)
					2'd0: hold_n = {16'h0000, data_byte};
					2'd1: hold_n = {hold_q[23:16], data_byte, hold_q[7:0]};
					2'd2: hold_n = {data_byte, hold_q[15:0]};
					2'd3: hold_n = hold_q;
				endcase
				if (sub_q == last_sub) begin
					emit  = 1'b1;
					col_n = col_q + 1'b1;
					sub_n = 2'd0;
				end else begin
					sub_n = sub_q + 2'd1;
				end
			end
			if (bir_q == row_last_q) begin
				// row done: drop padding, advance to the next row or finish after the last one
				bir_n = '0;
				col_n = '0;
				sub_n = 2'd0;
				if (row_q >= height_q) phase_n = PH_DONE;
				else row_n = row_q + 1'b1;
			end else begin
				bir_n = bir_q + 15'd1;
			end
		end

		if (phase_n == PH_HEADER) status = ST_BAD_SIG;
		else if (err_n != ST_OK) status = err_n;
		else if (phase_n != PH_DONE) status = ST_TRUNCATED;
		else status = ST_OK;

		decoded.has_pixel          = emit;
		decoded.has_status         = end_of_file;
		decoded.pixel.item_kind    = KIND_PIXEL;
		decoded.pixel.pixel_x      = col_q[11:0];
		decoded.pixel.pixel_y      = y_row[11:0];
		decoded.pixel.red          = hold_n[23:16];
		decoded.pixel.green        = hold_n[15:8];
		decoded.pixel.blue         = hold_n[7:0];
		decoded.pixel.alpha        = four_q ? data_byte : ALPHA_FULL;
		decoded.pixel.status_code  = ST_OK;
		decoded.pixel.last_of_run  = !end_of_file;
		decoded.status             = '0;
		decoded.status.item_kind   = KIND_STATUS;
		decoded.status.status_code = status;
		decoded.status.last_of_run = 1'b1;

		// end of file: back to the reset state for the next file
		if (end_of_file) begin
			pos_n        = '0;
			shift_n      = '0;
			data_start_n = '0;
			width_n      = '0;
			height_n     = '0;
			top_down_n   = 1'b0;
			four_n       = 1'b0;
			col_n        = '0;
			row_n        = '0;
			bir_n        = '0;
			sub_n        = 2'd0;
			hold_n       = '0;
			err_n        = ST_OK;
			phase_n      = PH_HEADER;
			row_data_n   = '0;
			row_last_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			shift_q      <= '0;
			data_start_q <= '0;
			width_q      <= '0;
			height_q     <= '0;
			top_down_q   <= 1'b0;
			four_q       <= 1'b0;
			col_q        <= '0;
			row_q        <= '0;
			bir_q        <= '0;
			sub_q        <= 2'd0;
			hold_q       <= '0;
			err_q        <= ST_OK;
			phase_q      <= PH_HEADER;
			row_data_q   <= '0;
			row_last_q   <= '0;
		end else if (step) begin
			pos_q        <= pos_n;
			shift_q      <= shift_n;
			data_start_q <= data_start_n;
			width_q      <= width_n;
			height_q     <= height_n;
			top_down_q   <= top_down_n;
			four_q       <= four_n;
			col_q        <= col_n;
			row_q        <= row_n;
			bir_q        <= bir_n;
			sub_q        <= sub_n;
			hold_q       <= hold_n;
			err_q        <= err_n;
			phase_q      <= phase_n;
			row_data_q   <= row_data_n;
			row_last_q   <= row_last_n;
		end
	end

endmodule
`default_nettype wire

// File: hdl/bmp2rgba_result_fifo.sv
// Small result queue: takes up to two results per byte, hands out one per beat.
`default_nettype none
module bmp2rgba_result_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  bmp2rgba_pkg::decode_out_t decoded,
	output logic                      room,
	bmp2rgba_result_if.source         results
);
	import bmp2rgba_pkg::*;

	localparam int unsigned CNT_W = $clog2(RESULT_DEPTH + 1);

	result_t                 entry_q [RESULT_DEPTH];
	logic [RESULT_PTR_W-1:0] wr_q;
	logic [RESULT_PTR_W-1:0] rd_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        n_push;
	logic [RESULT_PTR_W-1:0] n_push_ptr;
	logic                    pop;
	result_t                 head;

	assign n_push = push ? CNT_W'(decoded.has_pixel) + CNT_W'(decoded.has_status) : '0;
	assign n_push_ptr = n_push[RESULT_PTR_W-1:0];
	assign pop = results.valid && results.ready;
	// space for a full pair of results
	assign room = count_q <= CNT_W'(RESULT_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push && decoded.has_pixel) entry_q[wr_q] <= decoded.pixel;
		if (push && decoded.has_status) begin
			entry_q[wr_q + RESULT_PTR_W'(decoded.has_pixel)] <= decoded.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + n_push_ptr;
			rd_q    <= rd_q + RESULT_PTR_W'(pop);
			count_q <= count_q + n_push - CNT_W'(pop);
		end
	end

	assign head                = entry_q[rd_q];
	assign results.valid       = count_q != '0;
	assign results.item_kind   = head.item_kind;
	assign results.pixel_x     = head.pixel_x;
	assign results.pixel_y     = head.pixel_y;
	assign results.red         = head.red;
	assign results.green       = head.green;
	assign results.blue        = head.blue;
	assign results.alpha       = head.alpha;
	assign results.status_code = head.status_code;
	assign results.last_of_run = head.last_of_run;

endmodule
`default_nettype wire

// File: hdl/bmp_stream_to_rgba_pixels_core.sv
// BMP byte stream to RGBA pixel decoder, top level.
// Feed a 24- or 32-bit uncompressed BMP file one byte per beat on file_bytes,
// with end_of_file set on the final byte. The block takes one byte every cycle
// while the result queue has room; a byte is held in the input register, is
// decoded in a single pass against the file state, and its results enter a
// four-entry result queue, so a pixel passes the input register and the queue
// before it shows on results. A byte gives at most one pixel; the final byte
// also gives a status beat (code 0 ok, else the fault) at the end of the file.
// Input is held off only while the queue cannot take two more results, which
// happens when results stalls. Pixels come in file order with rows numbered
// from the top. After the status beat the block is ready for a new file.
`default_nettype none
module bmp_stream_to_rgba_pixels_core #(
	parameter int unsigned MAX_DIMENSION = bmp2rgba_pkg::MAX_DIMENSION_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	bmp2rgba_byte_if.sink      file_bytes,
	bmp2rgba_result_if.source  results
);
	import bmp2rgba_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eof_s1;
	logic        room;
	logic        advance;
	logic        accept;
	decode_out_t decoded;

	assign advance         = valid_s1 && room;
	assign file_bytes.ready = !valid_s1 || room;
	assign accept          = file_bytes.valid && file_bytes.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= file_bytes.data_byte;
			eof_s1  <= file_bytes.end_of_file;
		end
	end

	bmp2rgba_decode #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.data_byte   (byte_s1),
		.end_of_file (eof_s1),
		.decoded     (decoded)
	);

	bmp2rgba_result_fifo u_result_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (advance),
		.decoded (decoded),
		.room    (room),
		.results (results)
	);

endmodule
`default_nettype wire

// File: hdl/bmp2rgba_checker.sv
// Port-level checker of the BMP to RGBA decoder and its bind to the top level.
`default_nettype none
`include "bmp_stream_to_rgba_pixels_core_defines.svh"
module bmp2rgba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        item_kind,
	input logic [11:0] pixel_x,
	input logic [11:0] pixel_y,
	input logic [7:0]  red,
	input logic [7:0]  green,
	input logic [7:0]  blue,
	input logic [7:0]  alpha,
	input logic [2:0]  status_code,
	input logic        last_of_run
);
	import bmp2rgba_pkg::*;

	logic stalled;
	logic status_beat;
	logic pixel_beat;

	assign stalled     = out_valid && !out_ready;
	assign status_beat = out_valid && (item_kind == KIND_STATUS);
	assign pixel_beat  = out_valid && (item_kind == KIND_PIXEL);

	`BMP2RGBA_ASSERT_NEXT(a_stall_keeps_valid, stalled, out_valid, "result beat dropped while stalled")
	`BMP2RGBA_ASSERT_NEXT(a_stall_keeps_beat, stalled, $stable(item_kind) && $stable(pixel_x) && $stable(pixel_y) && $stable(status_code) && $stable(last_of_run), "result beat changed while stalled")
	`BMP2RGBA_ASSERT_NOW(a_pixel_status_ok, pixel_beat, status_code == ST_OK, "pixel beat with nonzero status")
	`BMP2RGBA_ASSERT_NOW(a_status_clean, status_beat, last_of_run && pixel_x == 12'd0 && pixel_y == 12'd0 && red == 8'd0 && green == 8'd0 && blue == 8'd0 && alpha == 8'd0, "status beat not last or carries pixel data")

endmodule

bind bmp_stream_to_rgba_pixels_core bmp2rgba_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.item_kind   (results.item_kind),
	.pixel_x     (results.pixel_x),
	.pixel_y     (results.pixel_y),
	.red         (results.red),
	.green       (results.green),
	.blue        (results.blue),
	.alpha       (results.alpha),
	.status_code (results.status_code),
	.last_of_run (results.last_of_run)
);
`default_nettype wire
